### design/grb_pkg.sv
package grb_pkg;

  localparam int MAX_GROUP_DEF   = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  // group_size register
  localparam int CFG_W = 5;
  localparam logic [CFG_W-1:0] GROUP_SIZE_RESET = CFG_W'(1);

  // read request from the sequencer to the output stage
  typedef struct packed {
    logic issue;  // a store read is issued this cycle
    logic last;   // the beat read carries the end-of-list mark
  } rd_req_t;

endpackage

### design/grb_ifs.sv
interface grb_in_if #(
  parameter int VALUE_WIDTH = grb_pkg::VALUE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] item_value;
  logic                          is_final;

  modport source (output valid, output item_value, output is_final, input ready);
  modport sink   (input valid, input item_value, input is_final, output ready);
endinterface

interface grb_out_if #(
  parameter int VALUE_WIDTH = grb_pkg::VALUE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] out_value;
  logic                          out_final;

  modport source (output valid, output out_value, output out_final, input ready);
  modport sink   (input valid, input out_value, input out_final, output ready);
endinterface

### design/grb_ram.sv
module grb_ram #(
  parameter int WIDTH = grb_pkg::VALUE_WIDTH_DEF,
  parameter int DEPTH = grb_pkg::MAX_GROUP_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/grb_out_stage.sv
module grb_out_stage #(
  parameter int VALUE_WIDTH = grb_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  grb_pkg::rd_req_t       rd_req,
  output logic                   can_issue,
  input  logic [VALUE_WIDTH-1:0] rdata,
  grb_out_if.source              out_ch
);

  // stage 1 is the store's read register; it holds while no read is issued
  logic s1_valid;
  logic s1_last;
  logic s1_move;

  assign s1_move   = s1_valid && (!out_ch.valid || out_ch.ready);
  assign can_issue = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (rd_req.issue) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_req.issue) begin
      s1_last <= rd_req.last;
    end
    if (s1_move) begin
      out_ch.out_value <= rdata;
      out_ch.out_final <= s1_last;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    rd_req.issue |-> (!s1_valid || s1_move))
    else $error("read issued into a full output pipe");

endmodule

### design/group_reversal_buffer.sv
// The beat that completes a group (or carries the end mark) is taken, the first
// store read is issued, the store's read register captures it and the output
// register raises out_ch.valid. A group of n values is written, then read back
// through one read port; input is held off while the group is read out.
// Reset: sequencer returns to filling, fill count cleared, group_size = 1;
// store contents are not cleared and are never read before being written.
module group_reversal_buffer #(
  parameter int MAX_GROUP   = grb_pkg::MAX_GROUP_DEF,
  parameter int VALUE_WIDTH = grb_pkg::VALUE_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  grb_in_if.sink                     in_ch,
  grb_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [grb_pkg::CFG_W-1:0]  cfg_wdata
);

  localparam int ADDR_W = $clog2(MAX_GROUP);
  localparam int CNT_W  = $clog2(MAX_GROUP + 1);
  localparam int CMP_W  = (CNT_W > grb_pkg::CFG_W) ? CNT_W : grb_pkg::CFG_W;

  localparam logic ST_FILL = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic                       state;
  logic [CNT_W-1:0]           fill_count;
  logic [grb_pkg::CFG_W-1:0]  group_size;
  logic [ADDR_W-1:0]          emit_top;
  logic [ADDR_W-1:0]          emit_cnt;
  logic                       emit_rev;
  logic                       emit_last;

  logic                       in_accept;
  logic [CNT_W-1:0]           n_held;
  logic [CMP_W-1:0]           gs_ext;
  logic [CMP_W-1:0]           k_eff;
  logic                       group_full;
  logic                       can_issue;
  logic                       emit_end;
  logic [ADDR_W-1:0]          rd_addr;
  logic [VALUE_WIDTH-1:0]     ram_rdata;
  grb_pkg::rd_req_t           rd_req;

  assign in_ch.ready = (state == ST_FILL);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign n_held      = fill_count + 1'b1;

  // zero means pass-through; oversize saturates to the store depth
  always_comb begin
    gs_ext = CMP_W'(group_size);
    if (group_size == '0) begin
      k_eff = CMP_W'(1);
    end else if (gs_ext > CMP_W'(MAX_GROUP)) begin
      k_eff = CMP_W'(MAX_GROUP);
    end else begin
      k_eff = gs_ext;
    end
  end

  assign group_full = CMP_W'(n_held) >= k_eff;

  assign emit_end     = (emit_cnt == emit_top);
  assign rd_addr      = emit_rev ? (emit_top - emit_cnt) : emit_cnt;
  assign rd_req.issue = (state == ST_EMIT) && can_issue;
  assign rd_req.last  = emit_last && emit_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_FILL;
      fill_count <= '0;
      group_size <= grb_pkg::GROUP_SIZE_RESET;
    end else begin
      if (cfg_we) begin
        group_size <= cfg_wdata;
      end
      unique case (state)
        ST_FILL: begin
          if (in_accept) begin
            if (group_full || in_ch.is_final) begin
              state      <= ST_EMIT;
              fill_count <= '0;
            end else begin
              fill_count <= n_held;
            end
          end
        end
        ST_EMIT: begin
          if (rd_req.issue && emit_end) begin
            state <= ST_FILL;
          end
        end
        default: state <= ST_FILL;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      emit_top  <= fill_count[ADDR_W-1:0];
      emit_cnt  <= '0;
      emit_rev  <= group_full;
      emit_last <= in_ch.is_final;
    end else if (rd_req.issue) begin
      emit_cnt <= emit_cnt + 1'b1;
    end
  end

  grb_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (MAX_GROUP)
  ) u_ram (
    .clk   (clk),
    .we    (in_accept),
    .waddr (fill_count[ADDR_W-1:0]),
    .wdata (in_ch.item_value),
    .re    (rd_req.issue),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  grb_out_stage #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .rd_req    (rd_req),
    .can_issue (can_issue),
    .rdata     (ram_rdata),
    .out_ch    (out_ch)
  );

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count < CNT_W'(MAX_GROUP))
    else $error("fill count reached store depth");

  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (emit_cnt <= emit_top))
    else $error("read-out index past end of group");

  a_final_flush: assert property (@(posedge clk) disable iff (rst)
    (in_accept && in_ch.is_final) |=> (state == ST_EMIT && fill_count == '0))
    else $error("end-of-list beat did not flush the store");

endmodule
